// ===== rtl/mau_pkg.sv =====
// Package: shared types and constants of the moving asymptote update core.
`default_nettype none
package mau_pkg;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [2:0] REG_FIRST_PASS = 3'd0;
   localparam logic [2:0] REG_CONTRACT   = 3'd1;
   localparam logic [2:0] REG_RELAX      = 3'd2;
   localparam logic [2:0] REG_INIT_OFF   = 3'd3;
   localparam logic [2:0] REG_MIN_OFF    = 3'd4;
   localparam logic [2:0] REG_MAX_OFF    = 3'd5;
   localparam logic [15:0] RST_CONTRACT = 16'd45875;
   localparam logic [19:0] RST_RELAX    = 20'd78643;
   localparam logic [21:0] RST_INIT_OFF = 22'd16384;
   localparam logic [31:0] RST_MIN_OFF  = 32'd43;
   localparam logic [23:0] RST_MAX_OFF  = 24'd6553600;
   localparam logic signed [33:0] INTERVAL_MIN = 34'sd655;
   localparam logic signed [33:0] INTERVAL_MAX = 34'sd6553600;
   localparam logic signed [17:0] WEIGHT_ASYM = 18'sd58982;
   localparam logic signed [17:0] WEIGHT_X    = 18'sd6554;

   typedef struct packed {
      logic        first_pass;
      logic [15:0] contract_factor;
      logic [19:0] relax_factor;
      logic [21:0] init_offset;
      logic [31:0] min_offset;
      logic [23:0] max_offset;
   } cfg_type;
endpackage
`default_nettype wire

// ===== rtl/mau_if.sv =====
// Interfaces: request and response channels of the update core.
`default_nettype none
interface mau_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] value_now;
   logic signed [31:0] value_prev;
   logic signed [31:0] value_prev2;
   logic signed [31:0] low_asym_old;
   logic signed [31:0] up_asym_old;
   logic signed [31:0] lower_bound;
   logic signed [31:0] upper_bound;
   logic signed [31:0] gradient;
   logic last_element;
   modport source (output valid, value_now, value_prev, value_prev2, low_asym_old,
      up_asym_old, lower_bound, upper_bound, gradient, last_element, input ready);
   modport sink (input valid, value_now, value_prev, value_prev2, low_asym_old,
      up_asym_old, lower_bound, upper_bound, gradient, last_element, output ready);
endinterface

interface mau_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] low_asym_new;
   logic signed [31:0] up_asym_new;
   logic signed [31:0] move_low;
   logic signed [31:0] move_high;
   logic [30:0] p_coeff;
   logic [30:0] q_coeff;
   logic [3:0] bad_flags;
   logic last_out;
   modport source (output valid, low_asym_new, up_asym_new, move_low, move_high,
      p_coeff, q_coeff, bad_flags, last_out, input ready);
   modport sink (input valid, low_asym_new, up_asym_new, move_low, move_high,
      p_coeff, q_coeff, bad_flags, last_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/moving_asymptote_update_core.sv =====
// Top level of the moving asymptote update core.
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | values, asymptotes, bounds, gradient, last
//  rsp     | out | valid/ready   | asymptotes, move limits, p, q, flags, last
//  csr     | in  | APB-style     | six factor and mode registers
// One item per cycle unless rsp stalls; items pass through the datapath pipeline.
// Synchronous active-high reset clears valid bits and loads register defaults.
// A stall on rsp freezes every stage; ready goes low only while the last stage is full.
`default_nettype none
module moving_asymptote_update_core #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   mau_req_if.sink req,
   mau_rsp_if.source rsp,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [mau_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   localparam int SAT_W = VALUE_WIDTH < 16 ? 16 : (VALUE_WIDTH > 32 ? 32 : VALUE_WIDTH);
   mau_pkg::cfg_type cfg;
   logic advance;

   mau_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   assign advance = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   mau_pipe #(.SAT_W(SAT_W)) u_pipe (
      .clock, .reset, .advance,
      .in_valid(req.valid), .cfg,
      .x_in(req.value_now), .x1_in(req.value_prev), .x2_in(req.value_prev2),
      .lo_in(req.low_asym_old), .up_in(req.up_asym_old),
      .lb_in(req.lower_bound), .ub_in(req.upper_bound), .g_in(req.gradient),
      .last_in(req.last_element),
      .out_valid(rsp.valid),
      .nl_out(rsp.low_asym_new), .nu_out(rsp.up_asym_new),
      .alpha_out(rsp.move_low), .beta_out(rsp.move_high),
      .p_out(rsp.p_coeff), .q_out(rsp.q_coeff),
      .flags_out(rsp.bad_flags), .last_out(rsp.last_out)
   );
endmodule
`default_nettype wire

// ===== rtl/mau_csr.sv =====
// Configuration register file with APB-style access.
`default_nettype none
module mau_csr (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [mau_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready,
   output mau_pkg::cfg_type cfg
);
   mau_pkg::cfg_type cfg_ff;
   logic [2:0] idx;
   logic wr;
   assign idx = csr_paddr[4:2];
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_pass <= 1'b1;
         cfg_ff.contract_factor <= mau_pkg::RST_CONTRACT;
         cfg_ff.relax_factor <= mau_pkg::RST_RELAX;
         cfg_ff.init_offset <= mau_pkg::RST_INIT_OFF;
         cfg_ff.min_offset <= mau_pkg::RST_MIN_OFF;
         cfg_ff.max_offset <= mau_pkg::RST_MAX_OFF;
      end else if (wr) begin
         case (idx)
            mau_pkg::REG_FIRST_PASS: cfg_ff.first_pass <= csr_pwdata[0];
            mau_pkg::REG_CONTRACT:   cfg_ff.contract_factor <= csr_pwdata[15:0];
            mau_pkg::REG_RELAX:      cfg_ff.relax_factor <= csr_pwdata[19:0];
            mau_pkg::REG_INIT_OFF:   cfg_ff.init_offset <= csr_pwdata[21:0];
            mau_pkg::REG_MIN_OFF:    cfg_ff.min_offset <= csr_pwdata;
            mau_pkg::REG_MAX_OFF:    cfg_ff.max_offset <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      case (idx)
         mau_pkg::REG_FIRST_PASS: csr_prdata = {31'd0, cfg_ff.first_pass};
         mau_pkg::REG_CONTRACT:   csr_prdata = {16'd0, cfg_ff.contract_factor};
         mau_pkg::REG_RELAX:      csr_prdata = {12'd0, cfg_ff.relax_factor};
         mau_pkg::REG_INIT_OFF:   csr_prdata = {10'd0, cfg_ff.init_offset};
         mau_pkg::REG_MIN_OFF:    csr_prdata = cfg_ff.min_offset;
         mau_pkg::REG_MAX_OFF:    csr_prdata = {8'd0, cfg_ff.max_offset};
         default: csr_prdata = 32'd0;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/mau_pipe.sv =====
// Datapath pipeline: asymptotes, move limits, coefficients and flags.
`default_nettype none
module mau_pipe #(
   parameter int SAT_W = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic advance,
   input  wire logic in_valid,
   input  wire mau_pkg::cfg_type cfg,
   input  wire logic signed [31:0] x_in,
   input  wire logic signed [31:0] x1_in,
   input  wire logic signed [31:0] x2_in,
   input  wire logic signed [31:0] lo_in,
   input  wire logic signed [31:0] up_in,
   input  wire logic signed [31:0] lb_in,
   input  wire logic signed [31:0] ub_in,
   input  wire logic signed [31:0] g_in,
   input  wire logic last_in,
   output logic out_valid,
   output logic signed [31:0] nl_out,
   output logic signed [31:0] nu_out,
   output logic signed [31:0] alpha_out,
   output logic signed [31:0] beta_out,
   output logic [30:0] p_out,
   output logic [30:0] q_out,
   output logic [3:0] flags_out,
   output logic last_out
);
   localparam logic signed [33:0] SMAX = 34'sd1 <<< (SAT_W - 1);
   localparam logic signed [33:0] SMAXV = SMAX - 34'sd1;
   localparam logic signed [33:0] SMINV = -SMAX;

   localparam int NST = 6;
   logic [NST-1:0] v_ff;
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (advance) v_ff <= {v_ff[NST-2:0], in_valid};
   end
   assign out_valid = v_ff[NST-1];

   function automatic logic signed [33:0] sat34(input logic signed [41:0] v);
      if (v > 42'(SMAXV)) return SMAXV;
      if (v < 42'(SMINV)) return SMINV;
      return v[33:0];
   endfunction

   // stage 1: span, interval, oscillation, differences
   logic signed [31:0] x1_ff, lb1_ff, ub1_ff, g1_ff;
   logic last1_ff, fp1_ff;
   logic signed [32:0] span1_ff, dl1_ff, du1_ff, iv1_ff;
   logic [19:0] f1_ff;
   logic signed [32:0] span_c, d1_c, d2_c;
   logic signed [33:0] iv_c;
   logic osc_c;
   always_comb begin
      span_c = 33'(ub_in) - 33'(lb_in);
      d1_c = 33'(x_in) - 33'(x1_in);
      d2_c = 33'(x1_in) - 33'(x2_in);
      osc_c = (d1_c < 0 && d2_c > 0) || (d1_c > 0 && d2_c < 0);
      iv_c = 34'(span_c);
      if (iv_c < mau_pkg::INTERVAL_MIN) iv_c = mau_pkg::INTERVAL_MIN;
      if (iv_c > mau_pkg::INTERVAL_MAX) iv_c = mau_pkg::INTERVAL_MAX;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff <= x_in; lb1_ff <= lb_in; ub1_ff <= ub_in; g1_ff <= g_in;
         last1_ff <= last_in; fp1_ff <= cfg.first_pass;
         span1_ff <= span_c;
         dl1_ff <= 33'(x1_in) - 33'(lo_in);
         du1_ff <= 33'(up_in) - 33'(x1_in);
         iv1_ff <= iv_c[32:0];
         f1_ff <= osc_c ? {4'd0, cfg.contract_factor} : cfg.relax_factor;
      end
   end

   // stage 2: products
   logic signed [31:0] x2_ff, lb2_ff, ub2_ff, g2_ff;
   logic last2_ff, fp2_ff;
   logic signed [56:0] pi2_ff;
   logic signed [54:0] pl2_ff, pu2_ff;
   logic signed [65:0] pn2_ff;
   logic signed [57:0] px2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         x2_ff <= x1_ff; lb2_ff <= lb1_ff; ub2_ff <= ub1_ff; g2_ff <= g1_ff;
         last2_ff <= last1_ff; fp2_ff <= fp1_ff;
         pi2_ff <= 57'($signed({1'b0, cfg.init_offset})) * 57'(span1_ff);
         pl2_ff <= 55'($signed({1'b0, f1_ff})) * 55'(dl1_ff);
         pu2_ff <= 55'($signed({1'b0, f1_ff})) * 55'(du1_ff);
         pn2_ff <= 66'($signed({1'b0, cfg.min_offset})) * 66'(iv1_ff);
         px2_ff <= 58'($signed({1'b0, cfg.max_offset})) * 58'(iv1_ff);
      end
   end

   // stage 3: round, clamp, saturate
   logic signed [41:0] off_c, rl_c, ru_c, mn_c, mx_c, nl_c, nu_c;
   always_comb begin
      off_c = 42'((pi2_ff + 57'sd32768) >>> 16);
      rl_c = 42'((pl2_ff + 55'sd32768) >>> 16);
      ru_c = 42'((pu2_ff + 55'sd32768) >>> 16);
      mn_c = 42'((pn2_ff + 66'sd2147483648) >>> 32);
      mx_c = 42'((px2_ff + 58'sd32768) >>> 16);
      if (fp2_ff) begin
         nl_c = 42'(x2_ff) - off_c;
         nu_c = 42'(x2_ff) + off_c;
      end else begin
         nl_c = 42'(x2_ff) - rl_c;
         nu_c = 42'(x2_ff) + ru_c;
         if (42'(x2_ff) - mn_c < nl_c) nl_c = 42'(x2_ff) - mn_c;
         if (42'(x2_ff) + mn_c > nu_c) nu_c = 42'(x2_ff) + mn_c;
         if (42'(x2_ff) - mx_c > nl_c) nl_c = 42'(x2_ff) - mx_c;
         if (42'(x2_ff) + mx_c < nu_c) nu_c = 42'(x2_ff) + mx_c;
      end
   end
   logic signed [31:0] x3_ff, lb3_ff, ub3_ff, g3_ff, nl3_ff, nu3_ff;
   logic last3_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         x3_ff <= x2_ff; lb3_ff <= lb2_ff; ub3_ff <= ub2_ff; g3_ff <= g2_ff;
         last3_ff <= last2_ff;
         nl3_ff <= 32'(sat34(nl_c));
         nu3_ff <= 32'(sat34(nu_c));
      end
   end

   // stage 4: weighted sums and squares
   logic signed [31:0] x4_ff, lb4_ff, ub4_ff, g4_ff, nl4_ff, nu4_ff;
   logic last4_ff;
   logic signed [51:0] wa4_ff, wb4_ff;
   logic [65:0] sp4_ff, sq4_ff;
   logic [32:0] dp_c, dq_c;
   logic signed [32:0] dps_c, dqs_c;
   always_comb begin
      dps_c = 33'(nu3_ff) - 33'(x3_ff);
      dqs_c = 33'(x3_ff) - 33'(nl3_ff);
      dp_c = dps_c < 0 ? 33'(-dps_c) : 33'(dps_c);
      dq_c = dqs_c < 0 ? 33'(-dqs_c) : 33'(dqs_c);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         x4_ff <= x3_ff; lb4_ff <= lb3_ff; ub4_ff <= ub3_ff; g4_ff <= g3_ff;
         nl4_ff <= nl3_ff; nu4_ff <= nu3_ff; last4_ff <= last3_ff;
         wa4_ff <= 52'(mau_pkg::WEIGHT_ASYM) * 52'(nl3_ff)
            + 52'(mau_pkg::WEIGHT_X) * 52'(x3_ff);
         wb4_ff <= 52'(mau_pkg::WEIGHT_ASYM) * 52'(nu3_ff)
            + 52'(mau_pkg::WEIGHT_X) * 52'(x3_ff);
         sp4_ff <= 66'(dp_c) * 66'(dp_c);
         sq4_ff <= 66'(dq_c) * 66'(dq_c);
      end
   end

   // stage 5: limits and coefficient partial products
   logic signed [35:0] ar_c, br_c;
   logic [49:0] sqpw_c, sqqw_c;
   logic [47:0] sqp_c, sqq_c;
   logic [31:0] mp_c, mq_c;
   always_comb begin
      ar_c = 36'((wa4_ff + 52'sd32768) >>> 16);
      br_c = 36'((wb4_ff + 52'sd32768) >>> 16);
      if (36'(lb4_ff) > ar_c) ar_c = 36'(lb4_ff);
      if (36'(ub4_ff) < br_c) br_c = 36'(ub4_ff);
      sqpw_c = 50'((sp4_ff + 66'd32768) >> 16);
      sqqw_c = 50'((sq4_ff + 66'd32768) >> 16);
      // any square above 2^47 is clamped to 2^47, which saturates the coefficient unless its gradient part is zero
      sqp_c = sqpw_c > 50'h800000000000 ? 48'h800000000000 : sqpw_c[47:0];
      sqq_c = sqqw_c > 50'h800000000000 ? 48'h800000000000 : sqqw_c[47:0];
      mp_c = g4_ff > 0 ? 32'(g4_ff) : 32'd0;
      mq_c = g4_ff < 0 ? 32'(-33'(g4_ff)) : 32'd0;
   end
   logic signed [31:0] x5_ff, nl5_ff, nu5_ff, a5_ff, b5_ff;
   logic last5_ff;
   logic [55:0] pph5_ff, ppl5_ff, pqh5_ff, pql5_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         x5_ff <= x4_ff; nl5_ff <= nl4_ff; nu5_ff <= nu4_ff; last5_ff <= last4_ff;
         a5_ff <= 32'(sat34(42'(ar_c)));
         b5_ff <= 32'(sat34(42'(br_c)));
         pph5_ff <= 56'(mp_c) * 56'(sqp_c[47:24]);
         ppl5_ff <= 56'(mp_c) * 56'(sqp_c[23:0]);
         pqh5_ff <= 56'(mq_c) * 56'(sqq_c[47:24]);
         pql5_ff <= 56'(mq_c) * 56'(sqq_c[23:0]);
      end
   end

   // stage 6: coefficient sum and rounding, flags
   localparam logic [80:0] THR = (81'(SMAX) << 16) - 81'd32768;
   logic [80:0] pp_c, pq_c;
   assign pp_c = 81'({pph5_ff, 24'd0}) + 81'(ppl5_ff);
   assign pq_c = 81'({pqh5_ff, 24'd0}) + 81'(pql5_ff);
   always_ff @(posedge clock) begin
      if (advance) begin
         nl_out <= nl5_ff; nu_out <= nu5_ff; alpha_out <= a5_ff; beta_out <= b5_ff;
         last_out <= last5_ff;
         p_out <= pp_c >= THR ? 31'(SMAXV) : 31'((pp_c + 81'd32768) >> 16);
         q_out <= pq_c >= THR ? 31'(SMAXV) : 31'((pq_c + 81'd32768) >> 16);
         flags_out <= {b5_ff >= nu5_ff, x5_ff > b5_ff, a5_ff > x5_ff, nl5_ff >= a5_ff};
      end
   end
endmodule
`default_nettype wire
